// ===== hdl/dlle_pkg.sv =====
`default_nettype none
package dlle_pkg;
  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DEL_KEY = 3'd1,
    KIND_DEL_FIRST = 3'd2,
    KIND_DEL_LAST = 3'd3,
    KIND_READ = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BEYOND = 2'd3
  } status_t;
endpackage
`default_nettype wire

// ===== hdl/dlle_ram.sv =====
`default_nettype none
module dlle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/doubly_linked_list_engine_unit.sv =====
// Channel | Dir | tdata fields (low bit up)                      | tuser
// s_axis  | in  | kind[2:0], key[34:3], position[40:35] (48 bits)| -
// m_axis  | out | value[31:0], status[33:32], entry_count[40:34] | -
// Steps: insert with a fresh node writes it and then gives the result beat;
// a freed node is reused only after its next link is read. Delete-first/last
// read the end node and unlink it. Delete by key and read pass through check,
// fetch and memory read per visited link. One command is in flight at a time.
// Reset: rst (sync, high) clears list pointers and counters; node memories
// are left unset, no clearing pass. Results sit in an output register;
// s_axis_tready is low while a command is in work or a result waits.
`default_nettype none
module doubly_linked_list_engine_unit #(
  parameter int NODES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // kind, key, position
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // value, status, entry_count
);
  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;           // link width, NODES means none
  localparam logic [LW-1:0] NONE = LW'(NODES);
  localparam int SW = (LW > 7) ? LW : 7; // walk step counter width

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FETCH  = 10'b0000000010,  // issue read of node n
    S_WAIT   = 10'b0000000100,  // read data returns
    S_CHECK  = 10'b0000001000,  // walk decision
    S_UNL_P  = 10'b0000010000,  // fix next of prev
    S_UNL_Q  = 10'b0000100000,  // fix prev of next
    S_UNL_F  = 10'b0001000000,  // push node on free list
    S_INS_A  = 10'b0010000000,  // free node taken, read its next
    S_INS_B  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  logic [2:0]  kind;
  logic [31:0] key;
  logic [5:0]  pos;
  logic [LW-1:0] front, back, free_head, cur, p_l, q_l;
  logic [LW:0] fresh, count;
  logic [SW-1:0] step;
  logic [31:0] res_value;
  logic [1:0]  res_status;

  // memories
  logic           we_k, we_n, we_p;
  logic [AW-1:0]  wa_k, wa_n, wa_p, ra;
  logic [31:0]    wd_k, rd_k;
  logic [LW-1:0]  wd_n, wd_p, rd_n, rd_p;

  dlle_ram #(.WIDTH(32), .DEPTH(NODES)) u_key (
    .clk, .we(we_k), .waddr(wa_k), .wdata(wd_k), .raddr(ra), .rdata(rd_k));
  dlle_ram #(.WIDTH(LW), .DEPTH(NODES)) u_next (
    .clk, .we(we_n), .waddr(wa_n), .wdata(wd_n), .raddr(ra), .rdata(rd_n));
  dlle_ram #(.WIDTH(LW), .DEPTH(NODES)) u_prev (
    .clk, .we(we_p), .waddr(wa_p), .wdata(wd_p), .raddr(ra), .rdata(rd_p));

  function automatic logic is_node(input logic [LW-1:0] n);
    return n < NONE;
  endfunction

  assign ra = cur[AW-1:0];
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    we_k = 1'b0; we_n = 1'b0; we_p = 1'b0;
    wa_k = cur[AW-1:0]; wa_n = cur[AW-1:0]; wa_p = cur[AW-1:0];
    wd_k = key; wd_n = front; wd_p = NONE;
    unique case (state)
      S_INS_B: begin
        // write new node, front keeps its prev fixed in a second write below
        we_k = 1'b1; we_n = 1'b1; we_p = 1'b1;
      end
      S_UNL_P: begin
        we_n = is_node(p_l); wa_n = p_l[AW-1:0]; wd_n = q_l;
      end
      S_UNL_Q: begin
        we_p = is_node(q_l); wa_p = q_l[AW-1:0]; wd_p = p_l;
      end
      S_UNL_F: begin
        we_n = 1'b1; wd_n = free_head;
      end
      S_DONE: begin
        // after insert: old front gets the new node as prev
        we_p = (kind == dlle_pkg::KIND_INSERT) && is_node(q_l)
               && (res_status == dlle_pkg::ST_OK);
        wa_p = q_l[AW-1:0]; wd_p = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= NONE; back <= NONE; free_head <= NONE;
      fresh <= '0; count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          kind <= s_axis_tdata[2:0];
          key  <= s_axis_tdata[34:3];
          pos  <= s_axis_tdata[40:35];
          res_value <= '0;
          res_status <= dlle_pkg::ST_OK;
          step <= '0;
          q_l <= NONE;
          priority case (s_axis_tdata[2:0])
            dlle_pkg::KIND_INSERT: begin
              if (is_node(free_head)) begin
                cur <= free_head; state <= S_INS_A;
              end else if (fresh < (LW+1)'(NODES)) begin
                cur <= fresh[LW-1:0]; fresh <= fresh + 1'b1; state <= S_INS_B;
              end else begin
                res_status <= dlle_pkg::ST_FULL; state <= S_DONE;
              end
            end
            dlle_pkg::KIND_DEL_KEY, dlle_pkg::KIND_READ: begin
              cur <= front; state <= S_CHECK;
            end
            dlle_pkg::KIND_DEL_FIRST: begin
              cur <= front; state <= S_CHECK;
            end
            dlle_pkg::KIND_DEL_LAST: begin
              cur <= back; state <= S_CHECK;
            end
            default: state <= S_DONE;
          endcase
        end
        S_INS_A: state <= S_WAIT;  // read of free node's next in flight
        S_INS_B: begin
          q_l <= front;
          if (!is_node(front)) back <= cur;
          front <= cur;
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_CHECK: begin
          // cur chosen; decide before reading
          if (!is_node(cur)) begin
            res_status <= (kind == dlle_pkg::KIND_READ) ? dlle_pkg::ST_BEYOND
                                                        : dlle_pkg::ST_NOTFOUND;
            state <= S_DONE;
          end else state <= S_FETCH;
        end
        S_FETCH: state <= S_WAIT;
        S_WAIT: begin
          if (kind == dlle_pkg::KIND_INSERT) begin
            free_head <= is_node(rd_n) ? rd_n : NONE;
            state <= S_INS_B;
          end else if (kind == dlle_pkg::KIND_READ) begin
            if (step == SW'(pos)) begin
              res_value <= rd_k; state <= S_DONE;
            end else begin
              step <= step + 1'b1; cur <= rd_n; state <= S_CHECK;
            end
          end else if (kind == dlle_pkg::KIND_DEL_KEY && rd_k != key) begin
            if (step == SW'(NODES - 1)) begin
              res_status <= dlle_pkg::ST_NOTFOUND; state <= S_DONE;
            end else begin
              step <= step + 1'b1; cur <= rd_n; state <= S_CHECK;
            end
          end else begin
            res_value <= rd_k; p_l <= rd_p; q_l <= rd_n; state <= S_UNL_P;
          end
        end
        S_UNL_P: begin
          if (!is_node(p_l)) front <= is_node(q_l) ? q_l : NONE;
          state <= S_UNL_Q;
        end
        S_UNL_Q: begin
          if (!is_node(q_l)) back <= is_node(p_l) ? p_l : NONE;
          state <= S_UNL_F;
        end
        S_UNL_F: begin
          free_head <= cur;
          if (count != '0) count <= count - 1'b1;
          q_l <= NONE;
          state <= S_DONE;
        end
        S_DONE: begin
          m_axis_tdata <= {7'd0, 7'(count), res_status, res_value};
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dlle_checker.sv =====
`default_nettype none
module dlle_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while busy");
  a_nores: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while result waits");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[40:34] <= 7'd64)
    else $error("count out of range");
endmodule

bind doubly_linked_list_engine_unit dlle_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
`default_nettype wire
